// ----- src/cpd_pkg.sv -----
`timescale 1ns / 1ps
// Package for the CRC-16 packet deframer: transaction structs, codes,
// reset values and the byte-wide CRC-16/MODBUS update. No dependencies.
package cpd_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
	localparam logic [15:0] MAX_LEN_RST     = 16'd240;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SYNC_FIRST  = 2'd0,
		REG_SYNC_SECOND = 2'd1,
		REG_MAX_LENGTH  = 2'd2
	} cpd_reg_t;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_SEQ   = 3'd2,
		PH_LEN   = 3'd3,
		PH_PAY   = 3'd4,
		PH_CRC   = 3'd5
	} cpd_phase_t;

	typedef enum logic [1:0] {
		ST_GOOD    = 2'd0,
		ST_CRC_BAD = 2'd1,
		ST_LEN_BAD = 2'd2
	} cpd_status_t;

	localparam logic ACT_BYTE    = 1'b0;
	localparam logic ACT_RESTART = 1'b1;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} cpd_in_t;

	typedef struct packed {
		cpd_status_t frame_status;
		logic [31:0] frame_sequence;
		logic [15:0] frame_length;
		logic        sequence_gap;
		logic [15:0] received_check;
		logic [15:0] computed_check;
		logic [31:0] good_byte_total;
		logic [31:0] check_error_total;
		logic [31:0] gap_error_total;
	} cpd_out_t;

	typedef struct packed {
		logic [7:0]  sync_first;
		logic [7:0]  sync_second;
		logic [15:0] max_payload_length;
	} cpd_cfg_t;

	// Reflected CRC-16 over one byte, LSB first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- src/cpd_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration register file of the deframer: sync bytes and length limit.
// Depends on cpd_pkg.
module cpd_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [cpd_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [cpd_pkg::CFG_DATA_W-1:0]       cfg_data,
	output cpd_pkg::cpd_cfg_t                    cfg
);

	cpd_pkg::cpd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first         <= cpd_pkg::SYNC_FIRST_RST;
			cfg_q.sync_second        <= cpd_pkg::SYNC_SECOND_RST;
			cfg_q.max_payload_length <= cpd_pkg::MAX_LEN_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				cpd_pkg::REG_SYNC_FIRST: begin
					cfg_q.sync_first <= cfg_data[7:0];
				end
				cpd_pkg::REG_SYNC_SECOND: begin
					cfg_q.sync_second <= cfg_data[7:0];
				end
				cpd_pkg::REG_MAX_LENGTH: begin
					cfg_q.max_payload_length <= cfg_data[15:0];
				end
				default: begin
					// unmapped index: ignored
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/cpd_frame_fsm.sv -----
`timescale 1ns / 1ps
// Frame parser: sync hunt, header/payload/CRC fields, running CRC and the
// saturating counters. Produces at most one result per byte. Depends on cpd_pkg.
module cpd_frame_fsm #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  cpd_pkg::cpd_in_t  item,
	input  cpd_pkg::cpd_cfg_t cfg,
	output logic              res_valid,
	output cpd_pkg::cpd_out_t res
);

	cpd_pkg::cpd_phase_t phase_q, phase_d;
	logic [15:0]            pos_q, pos_d;
	logic [15:0]            crc_q, crc_d;
	logic [31:0]            seq_q, seq_d;
	logic [15:0]            len_q, len_d;
	logic [15:0]            carried_q, carried_d;
	logic [31:0]            exp_q, exp_d;
	logic                   expv_q, expv_d;
	logic [COUNT_WIDTH-1:0] good_q, good_d;
	logic [COUNT_WIDTH-1:0] cerr_q, cerr_d;
	logic [COUNT_WIDTH-1:0] gerr_q, gerr_d;

	logic [7:0]  b;
	logic [15:0] crc_upd;
	logic [31:0] seq_ins;
	logic [15:0] len_ins;
	logic [15:0] car_ins;
	logic [15:0] pos_inc;
	logic        gap;

	cpd_pkg::cpd_status_t res_status;
	logic        res_gap;
	logic [15:0] res_len;
	logic [15:0] res_rx;
	logic [15:0] res_comp;

	function automatic logic [COUNT_WIDTH-1:0] sat_add(
		input logic [COUNT_WIDTH-1:0] a,
		input logic [15:0]            inc
	);
		logic [COUNT_WIDTH:0] sum;
		sum = {1'b0, a} + (COUNT_WIDTH+1)'(inc);
		return sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
	endfunction

	function automatic logic [31:0] clamp32(input logic [COUNT_WIDTH-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return (|w[63:32]) ? 32'hFFFF_FFFF : w[31:0];
	endfunction

	assign b       = item.rx_byte;
	assign crc_upd = cpd_pkg::crc_byte(crc_q, b);
	assign seq_ins = seq_q | (32'(b) << {pos_q[1:0], 3'b000});
	assign len_ins = len_q | (16'(b) << {pos_q[0], 3'b000});
	assign car_ins = carried_q | (16'(b) << {pos_q[0], 3'b000});
	assign pos_inc = pos_q + 16'd1;
	assign gap     = expv_q && (seq_q != exp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= cpd_pkg::PH_HUNT;
			pos_q     <= '0;
			crc_q     <= cpd_pkg::CRC_INIT;
			seq_q     <= '0;
			len_q     <= '0;
			carried_q <= '0;
			exp_q     <= '0;
			expv_q    <= 1'b0;
			good_q    <= '0;
			cerr_q    <= '0;
			gerr_q    <= '0;
		end else begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			crc_q     <= crc_d;
			seq_q     <= seq_d;
			len_q     <= len_d;
			carried_q <= carried_d;
			exp_q     <= exp_d;
			expv_q    <= expv_d;
			good_q    <= good_d;
			cerr_q    <= cerr_d;
			gerr_q    <= gerr_d;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		crc_d      = crc_q;
		seq_d      = seq_q;
		len_d      = len_q;
		carried_d  = carried_q;
		exp_d      = exp_q;
		expv_d     = expv_q;
		good_d     = good_q;
		cerr_d     = cerr_q;
		gerr_d     = gerr_q;
		res_valid  = 1'b0;
		res_status = cpd_pkg::ST_GOOD;
		res_gap    = 1'b0;
		res_len    = len_q;
		res_rx     = '0;
		res_comp   = crc_q;

		if (en) begin
			if (item.action == cpd_pkg::ACT_RESTART) begin
				phase_d   = cpd_pkg::PH_HUNT;
				pos_d     = '0;
				crc_d     = cpd_pkg::CRC_INIT;
				seq_d     = '0;
				len_d     = '0;
				carried_d = '0;
				exp_d     = '0;
				expv_d    = 1'b0;
				good_d    = '0;
				cerr_d    = '0;
				gerr_d    = '0;
			end else begin
				case (phase_q)
					cpd_pkg::PH_HUNT: begin
						if (b == cfg.sync_first) begin
							phase_d = cpd_pkg::PH_SYNC2;
						end
					end
					cpd_pkg::PH_SYNC2: begin
						if (b == cfg.sync_second) begin
							phase_d   = cpd_pkg::PH_SEQ;
							pos_d     = '0;
							crc_d     = cpd_pkg::CRC_INIT;
							seq_d     = '0;
							len_d     = '0;
							carried_d = '0;
						end else if (b != cfg.sync_first) begin
							phase_d = cpd_pkg::PH_HUNT;
						end
					end
					cpd_pkg::PH_SEQ: begin
						seq_d = seq_ins;
						crc_d = crc_upd;
						if (pos_q[1:0] == 2'd3) begin
							pos_d   = '0;
							phase_d = cpd_pkg::PH_LEN;
						end else begin
							pos_d = pos_inc;
						end
					end
					cpd_pkg::PH_LEN: begin
						len_d = len_ins;
						crc_d = crc_upd;
						if (!pos_q[0]) begin
							pos_d = pos_inc;
						end else if (len_ins == 16'd0 || len_ins > cfg.max_payload_length) begin
							// rejected length: report, then hunt from the next byte
							cerr_d     = sat_add(cerr_q, 16'd1);
							res_valid  = 1'b1;
							res_status = cpd_pkg::ST_LEN_BAD;
							res_len    = len_ins;
							res_comp   = crc_upd;
							phase_d    = cpd_pkg::PH_HUNT;
							pos_d      = '0;
							crc_d      = cpd_pkg::CRC_INIT;
							seq_d      = '0;
							len_d      = '0;
							carried_d  = '0;
						end else begin
							pos_d   = '0;
							phase_d = cpd_pkg::PH_PAY;
						end
					end
					cpd_pkg::PH_PAY: begin
						crc_d = crc_upd;
						if (pos_inc >= len_q) begin
							pos_d   = '0;
							phase_d = cpd_pkg::PH_CRC;
						end else begin
							pos_d = pos_inc;
						end
					end
					cpd_pkg::PH_CRC: begin
						carried_d = car_ins;
						if (!pos_q[0]) begin
							pos_d = pos_inc;
						end else begin
							res_valid = 1'b1;
							res_rx    = car_ins;
							if (car_ins != crc_q) begin
								cerr_d     = sat_add(cerr_q, 16'd1);
								res_status = cpd_pkg::ST_CRC_BAD;
							end else begin
								res_gap = gap;
								if (gap) begin
									gerr_d = sat_add(gerr_q, 16'd1);
								end
								exp_d  = seq_q + 32'd1;
								expv_d = 1'b1;
								good_d = sat_add(good_q, len_q);
							end
							phase_d   = cpd_pkg::PH_HUNT;
							pos_d     = '0;
							crc_d     = cpd_pkg::CRC_INIT;
							seq_d     = '0;
							len_d     = '0;
							carried_d = '0;
						end
					end
					default: begin
						phase_d   = cpd_pkg::PH_HUNT;
						pos_d     = '0;
						crc_d     = cpd_pkg::CRC_INIT;
						seq_d     = '0;
						len_d     = '0;
						carried_d = '0;
					end
				endcase
			end
		end
	end

	always_comb begin
		res.frame_status      = res_status;
		res.frame_sequence    = seq_q;
		res.frame_length      = res_len;
		res.sequence_gap      = res_gap;
		res.received_check    = res_rx;
		res.computed_check    = res_comp;
		res.good_byte_total   = clamp32(good_d);
		res.check_error_total = clamp32(cerr_d);
		res.gap_error_total   = clamp32(gerr_d);
	end

endmodule

// ----- src/crc16_packet_deframer.sv -----
`timescale 1ns / 1ps
// Top level of the sync/length/CRC-16 packet deframer: input register,
// frame parser, result register. Depends on cpd_pkg, cpd_cfg_regs, cpd_frame_fsm.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+---------------------------
//  byte      | in        | byte_valid / byte_stall | byte_item  (cpd_in_t)
//  frame     | out       | frame_valid/frame_stall | frame_result (cpd_out_t)
//  cfg       | in        | cfg_write               | cfg_index, cfg_data
//
// One byte transaction per cycle sustained unless a result is held under frame_stall.
// A byte waits in the input register until the parser consumes it; a result it
// causes is loaded into the result register at the edge that ends the cycle in
// which the parser consumes the byte, and frame_valid is driven from that register.
// The combinational path between registers is the byte-wide CRC update (eight
// unrolled steps) plus the header field compares.
// Reset (arst_n low) restores the default sync bytes and length limit, clears
// all counters and the sequence expectation, and starts in sync hunt.
// While a result sits in the result register under frame_stall, the parser
// holds; once the input register is also full, byte_stall goes high.
module crc16_packet_deframer #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// byte channel
	input  logic                                  byte_valid,
	output logic                                  byte_stall,
	input  cpd_pkg::cpd_in_t                      byte_item,
	// result channel
	output logic                                  frame_valid,
	input  logic                                  frame_stall,
	output cpd_pkg::cpd_out_t                     frame_result,
	// configuration write port
	input  logic                                  cfg_write,
	input  logic [cpd_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [cpd_pkg::CFG_DATA_W-1:0]        cfg_data
);

	cpd_pkg::cpd_cfg_t cfg;

	// input register
	logic             valid_s1;
	cpd_pkg::cpd_in_t item_s1;

	// result register
	logic              out_valid_q;
	cpd_pkg::cpd_out_t out_q;

	logic              advance;
	logic              res_valid;
	cpd_pkg::cpd_out_t res;

	// Parser consumes the buffered byte whenever the result slot is free or
	// is being taken this cycle.
	assign advance    = valid_s1 && (!out_valid_q || !frame_stall);
	assign byte_stall = valid_s1 && !advance;

	cpd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cpd_frame_fsm #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			item_s1 <= byte_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!frame_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign frame_valid  = out_valid_q;
	assign frame_result = out_q;

	// byte_stall only when both stages are full and the output is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (frame_valid && frame_stall && valid_s1))
		else $error("byte_stall without a blocked result register");

	// a gap is only ever flagged on a good frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && frame_result.sequence_gap) |->
		(frame_result.frame_status == cpd_pkg::ST_GOOD))
		else $error("sequence gap on a rejected frame");

	// rejected length carries no received CRC
	assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && frame_result.frame_status == cpd_pkg::ST_LEN_BAD) |->
		(frame_result.received_check == 16'd0))
		else $error("invalid-length result with nonzero received check");

	// a new result is loaded only into a free or draining result register
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid) |-> (!out_valid_q || !frame_stall))
		else $error("result overwrote a stalled transaction");

endmodule
